### rtl/recent_address_locality_monitor_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the recent address locality monitor
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RECENT_ADDRESS_LOCALITY_MONITOR_UNIT_DEFINES_SVH
`define RECENT_ADDRESS_LOCALITY_MONITOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define RALM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ralm: same-cycle check failed");
// next-cycle implication
`define RALM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ralm: next-cycle check failed");
`else
`define RALM_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define RALM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/ralm_pkg.sv
// ----------------------------------------------------------------------------
// Recent address locality monitor package
// Field widths, parameter defaults and shared control types.
// ----------------------------------------------------------------------------
package ralm_pkg;

  localparam int ThreadIdW = 3;
  localparam int AddrW     = 64;
  localparam int CountW    = 32;

  localparam int DefRingDepth   = 32;
  localparam int DefThreadCount = 8;

  localparam logic [CountW-1:0] DefReportInterval = 32'd1000000;

  // ring store strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_ctrl_t;

endpackage

### rtl/ralm_in_if.sv
// ----------------------------------------------------------------------------
// Access input channel
// Valid/ready stream carrying thread number and address.
// ----------------------------------------------------------------------------
interface ralm_in_if;
  logic                                valid;
  logic                                ready;
  logic [ralm_pkg::ThreadIdW-1:0]      thread_id;
  logic [ralm_pkg::AddrW-1:0]          address;

  modport source (output valid, thread_id, address, input ready);
  modport sink   (input valid, thread_id, address, output ready);
endinterface

### rtl/ralm_out_if.sv
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready stream carrying hit flag and interval report.
// ----------------------------------------------------------------------------
interface ralm_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic                                report;
  logic [ralm_pkg::ThreadIdW-1:0]      report_thread;
  logic [ralm_pkg::CountW-1:0]         interval_hits;
  logic [ralm_pkg::CountW-1:0]         interval_accesses;

  modport source (output valid, hit, report, report_thread, interval_hits,
                  interval_accesses, input ready);
  modport sink   (input valid, hit, report, report_thread, interval_hits,
                  interval_accesses, output ready);
endinterface

### rtl/ralm_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready write of the report interval register.
// ----------------------------------------------------------------------------
interface ralm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ralm_pkg::CountW-1:0]         data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### rtl/ralm_ring_store.sv
// ----------------------------------------------------------------------------
// Recent address ring store
// One memory for all thread rings with a registered read port and the
// shared 64-bit equality compare against the access address.
// ----------------------------------------------------------------------------
module ralm_ring_store #(
  parameter int AW = 8
) (
  input  logic                         clk_i,
  input  ralm_pkg::ring_ctrl_t         ctrl_i,
  input  logic [AW-1:0]                rd_addr_i,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic [ralm_pkg::AddrW-1:0]   wr_data_i,
  input  logic [ralm_pkg::AddrW-1:0]   cmp_addr_i,
  output logic                         match_o
);

  logic [ralm_pkg::AddrW-1:0] mem [2**AW];
  logic [ralm_pkg::AddrW-1:0] rd_data_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // shared compare unit
  assign match_o = (rd_data_q == cmp_addr_i);

endmodule

### rtl/recent_address_locality_monitor_unit.sv
// ----------------------------------------------------------------------------
// Recent address locality monitor
// Per-thread ring of recent addresses with hit and access interval counters.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                         | accept
//  ---------+-----+-------------------------------------------------+-------------
//  in_i     | in  | thread_id, address                              | valid&ready
//  out_o    | out | hit, report, report_thread, interval_hits/acc.  | valid&ready
//  cfg_i    | in  | data (report_interval)                          | valid&ready
//
//  An access in range passes from its transfer until in_i.ready returns
//  through one load step, then one ring entry read and compared per cycle
//  through the single ring read port, then one update step and one result
//  step. A thread at or beyond THREAD_COUNT goes straight to the result step.
//  out_o is a holding register:
//  a stalled result blocks only the final step of the following access.
//  Reset needs no clearing pass: per-thread valid bits and fill tracking make
//  unwritten ring entries and thread state read as zero.
//  cfg_i is always ready.
// ----------------------------------------------------------------------------
`include "recent_address_locality_monitor_unit_defines.svh"

module recent_address_locality_monitor_unit #(
  parameter int RING_DEPTH   = ralm_pkg::DefRingDepth,
  parameter int THREAD_COUNT = ralm_pkg::DefThreadCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ralm_in_if.sink     in_i,
  ralm_cfg_if.sink    cfg_i,
  ralm_out_if.source  out_o
);

  localparam int PosW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int TidW  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
  localparam int ExtW  = TidW + ralm_pkg::ThreadIdW;
  localparam int CW    = ralm_pkg::CountW;
  localparam int TsW   = 1 + PosW + 2 * CW;

  localparam logic [PosW-1:0] LastPos = PosW'(RING_DEPTH - 1);
  localparam logic [ExtW-1:0] ThreadLim = ExtW'(THREAD_COUNT);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_q, state_d;

  // per-thread state memory: {full, position, hits, accesses}
  logic [TsW-1:0]          ts_mem [THREAD_COUNT];
  logic [TsW-1:0]          ts_rdata_q;
  logic [THREAD_COUNT-1:0] ts_valid_q;

  logic [CW-1:0]                    interval_q;
  logic [ralm_pkg::ThreadIdW-1:0]   tid_q;
  logic [TidW-1:0]                  tidx_q;
  logic [ralm_pkg::AddrW-1:0]       addr_q;
  logic [PosW-1:0]                  pos_q;
  logic                             full_q;
  logic [CW-1:0]                    acc_q;
  logic [CW-1:0]                    hits_q;
  logic [PosW-1:0]                  cmp_idx_q;
  logic                             hit_q;

  logic                             res_hit_q, res_report_q;
  logic [CW-1:0]                    res_hits_q, res_acc_q;

  logic                             out_valid_q;
  logic                             out_hit_q, out_report_q;
  logic [ralm_pkg::ThreadIdW-1:0]   out_tid_q;
  logic [CW-1:0]                    out_hits_q, out_acc_q;

  logic                             in_xfer, out_free;
  logic [ExtW-1:0]                  in_tid_ext;
  logic [TidW-1:0]                  in_tidx;
  logic                             in_range;

  logic                             scan_last, entry_valid, match, addr_zero;
  logic [PosW-1:0]                  pos_nx;
  logic                             full_nx;
  logic [CW-1:0]                    acc_nx, hits_nx;
  logic                             report_nx;

  ralm_pkg::ring_ctrl_t             ring_ctrl;
  logic [PosW-1:0]                  ring_rd_idx;

  // handshakes and thread decode
  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_tid_ext  = ExtW'(in_i.thread_id);
  assign in_tidx     = in_tid_ext[TidW-1:0];
  assign in_range    = (in_tid_ext < ThreadLim);

  // scan control
  assign scan_last   = (cmp_idx_q == LastPos);
  assign entry_valid = full_q || (cmp_idx_q < pos_q);
  assign addr_zero   = (addr_q == '0);
  assign ring_rd_idx = (state_q == S_LOAD) ? '0 : cmp_idx_q + PosW'(1);
  assign ring_ctrl.rd_en = (state_q == S_LOAD) || (state_q == S_SCAN);
  assign ring_ctrl.wr_en = (state_q == S_UPDATE);

  // update arithmetic
  assign pos_nx    = (pos_q == LastPos) ? '0 : pos_q + PosW'(1);
  assign full_nx   = full_q || (pos_q == LastPos);
  assign acc_nx    = acc_q + CW'(1);
  assign hits_nx   = hits_q + CW'(hit_q);
  assign report_nx = (acc_nx >= interval_q);

  ralm_ring_store #(
    .AW (TidW + PosW)
  ) u_ring (
    .clk_i      (clk_i),
    .ctrl_i     (ring_ctrl),
    .rd_addr_i  ({tidx_q, ring_rd_idx}),
    .wr_addr_i  ({tidx_q, pos_q}),
    .wr_data_i  (addr_q),
    .cmp_addr_i (addr_q),
    .match_o    (match)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = in_range ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: begin
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (scan_last) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      ts_valid_q  <= '0;
      interval_q  <= ralm_pkg::DefReportInterval;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        interval_q <= cfg_i.data;
      end
      if (state_q == S_UPDATE) begin
        ts_valid_q[tidx_q] <= 1'b1;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // thread state memory
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ts_rdata_q <= ts_mem[in_tidx];
    end
    if (state_q == S_UPDATE) begin
      ts_mem[tidx_q] <= report_nx ? {full_nx, pos_nx, {2 * CW{1'b0}}}
                                  : {full_nx, pos_nx, hits_nx, acc_nx};
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          tid_q        <= in_i.thread_id;
          tidx_q       <= in_tidx;
          addr_q       <= in_i.address;
          res_hit_q    <= 1'b0;
          res_report_q <= 1'b0;
          res_hits_q   <= '0;
          res_acc_q    <= '0;
        end
      end
      S_LOAD: begin
        if (ts_valid_q[tidx_q]) begin
          {full_q, pos_q, hits_q, acc_q} <= ts_rdata_q;
        end else begin
          {full_q, pos_q, hits_q, acc_q} <= '0;
        end
        cmp_idx_q <= '0;
        hit_q     <= 1'b0;
      end
      S_SCAN: begin
        // an entry not yet written is compared as if it held zero
        hit_q     <= hit_q || (entry_valid ? match : addr_zero);
        cmp_idx_q <= cmp_idx_q + PosW'(1);
      end
      S_UPDATE: begin
        res_hit_q    <= hit_q;
        res_report_q <= report_nx;
        res_hits_q   <= report_nx ? hits_nx : '0;
        res_acc_q    <= report_nx ? acc_nx : '0;
      end
      S_DONE: begin
        if (out_free) begin
          out_hit_q    <= res_hit_q;
          out_report_q <= res_report_q;
          out_tid_q    <= tid_q;
          out_hits_q   <= res_hits_q;
          out_acc_q    <= res_acc_q;
        end
      end
      default: begin
      end
    endcase
  end

  // output channel
  assign out_o.valid             = out_valid_q;
  assign out_o.hit               = out_hit_q;
  assign out_o.report            = out_report_q;
  assign out_o.report_thread     = out_tid_q;
  assign out_o.interval_hits     = out_hits_q;
  assign out_o.interval_accesses = out_acc_q;

  // assertions
  `RALM_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, !in_i.ready)
  `RALM_ASSERT_NOW(a_no_report_zero, clk_i, rst_ni, out_o.valid && !out_o.report,
                   out_o.interval_hits == '0 && out_o.interval_accesses == '0)
  `RALM_ASSERT_NOW(a_hits_le_acc, clk_i, rst_ni, out_o.valid && out_o.report,
                   out_o.interval_hits <= out_o.interval_accesses)
  `RALM_ASSERT_NEXT(a_scan_exit, clk_i, rst_ni, state_q == S_SCAN && scan_last,
                    state_q == S_UPDATE)

endmodule

### dv/recent_address_locality_monitor_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Recent address locality monitor testbench
// Drives accesses through a directed table and then random traffic over
// several report intervals, keeps its own per-thread rings and counters,
// and checks every result transfer in order against that prediction or a table row's expected result.
// ----------------------------------------------------------------------------
module recent_address_locality_monitor_unit_tb;

  localparam int ThreadIdW  = ralm_pkg::ThreadIdW;
  localparam int AddrW      = ralm_pkg::AddrW;
  localparam int CountW     = ralm_pkg::CountW;
  localparam int RingDepth  = ralm_pkg::DefRingDepth;
  localparam int NumThreads = ralm_pkg::DefThreadCount;
  localparam int PoolSize   = 40;
  localparam int PhaseItems = 250;
  localparam int NumPhases  = 7;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic                 hit;
    logic                 report;
    logic [ThreadIdW-1:0] report_thread;
    logic [CountW-1:0]    interval_hits;
    logic [CountW-1:0]    interval_accesses;
  } access_result_t;

  typedef enum logic {ROW_ACCESS, ROW_CONFIG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [ThreadIdW-1:0] thread_id;
    logic [AddrW-1:0]     address;   // interval value on a config row
    bit                   typed;
    access_result_t       want;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  ralm_in_if  in_if ();
  ralm_cfg_if cfg_if ();
  ralm_out_if out_if ();

  recent_address_locality_monitor_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  // Shadow state of the block
  logic [AddrW-1:0]  recent_addr [NumThreads][RingDepth];
  int                ring_slot   [NumThreads];
  logic [CountW-1:0] acc_cnt     [NumThreads];
  logic [CountW-1:0] hit_cnt     [NumThreads];
  logic [CountW-1:0] interval_reg;

  access_result_t pending_results [$];
  stim_row_t      directed_rows [$];
  logic [AddrW-1:0] addr_pool [PoolSize];
  logic [AddrW-1:0] last_addr [NumThreads];

  int fault_count  = 0;
  int src_calm     = 0;
  int sink_calm    = 0;
  int rx_wait      = 0;
  bit sink_blocked = 1'b0;
  bit hold_off_req = 1'b0;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #(5_000_000);
    $display("recent_address_locality_monitor_unit test failed");
    $finish;
  end

  // Per-item wait, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Lookup, ring update and interval counting for one access
  function automatic access_result_t predict_access(input logic [ThreadIdW-1:0] tid,
                                                    input logic [AddrW-1:0] addr);
    access_result_t r;
    logic matched;
    r = '0;
    matched = 1'b0;
    for (int i = 0; i < RingDepth; i++) begin
      if (recent_addr[tid][i] == addr) matched = 1'b1;
    end
    acc_cnt[tid] += CountW'(1);
    if (matched) hit_cnt[tid] += CountW'(1);
    recent_addr[tid][ring_slot[tid]] = addr;
    ring_slot[tid] = (ring_slot[tid] + 1) % RingDepth;
    r.hit = matched;
    r.report_thread = tid;
    // ">=" so a lowered interval fires on the next access
    if (acc_cnt[tid] >= interval_reg) begin
      r.report = 1'b1;
      r.interval_hits = hit_cnt[tid];
      r.interval_accesses = acc_cnt[tid];
      hit_cnt[tid] = '0;
      acc_cnt[tid] = '0;
    end
    return r;
  endfunction

  function automatic stim_row_t acc_row(input logic [ThreadIdW-1:0] tid,
                                        input logic [AddrW-1:0] addr);
    stim_row_t row;
    row = '{ROW_ACCESS, tid, addr, 1'b0, '0};
    return row;
  endfunction

  function automatic stim_row_t chk_row(input logic [ThreadIdW-1:0] tid,
                                        input logic [AddrW-1:0] addr,
                                        input logic hit, input logic rep,
                                        input logic [CountW-1:0] hits,
                                        input logic [CountW-1:0] accs);
    stim_row_t row;
    row = '{ROW_ACCESS, tid, addr, 1'b1, '{hit, rep, tid, hits, accs}};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CountW-1:0] value);
    stim_row_t row;
    row = '{ROW_CONFIG, '0, {32'd0, value}, 1'b0, '0};
    return row;
  endfunction

  // Offer one access, wait for its transfer, then log the expected result
  task automatic send_access(input logic [ThreadIdW-1:0] tid,
                             input logic [AddrW-1:0] addr,
                             input bit typed, input access_result_t want);
    int gap;
    access_result_t predicted;
    gap = draw_wait(src_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.thread_id <= tid;
    in_if.address   <= addr;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = predict_access(tid, addr);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Interval write, only once every result is out
  task automatic write_interval(input logic [CountW-1:0] value);
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    interval_reg = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Result side ready, with a random stall after each transfer
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_wait > 0) rx_wait--;
      out_if.ready <= (rx_wait == 0) && !sink_blocked;
    end
  end

  // Long hold-off so the result register fills and the input backs up
  initial begin
    wait (hold_off_req);
    @(posedge clk_i);
    sink_blocked = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    sink_blocked = 1'b0;
  end

  // Result checker
  always @(posedge clk_i) begin : result_check
    access_result_t want;
    access_result_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.hit, out_if.report, out_if.report_thread,
              out_if.interval_hits, out_if.interval_accesses};
      if (pending_results.size() == 0) begin
        if (fault_count < 10)
          $display("%0t: result transfer with nothing expected: hit=%0b rep=%0b thr=%0d",
                   $realtime, got.hit, got.report, got.report_thread);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit || got.report !== want.report ||
            got.report_thread !== want.report_thread ||
            got.interval_hits !== want.interval_hits ||
            got.interval_accesses !== want.interval_accesses) begin
          if (fault_count < 10)
            $display("%0t: mismatch exp hit=%0b rep=%0b thr=%0d hits=%0d acc=%0d",
                     $realtime, want.hit, want.report, want.report_thread,
                     want.interval_hits, want.interval_accesses,
                     " | got hit=%0b rep=%0b thr=%0d hits=%0d acc=%0d",
                     got.hit, got.report, got.report_thread,
                     got.interval_hits, got.interval_accesses);
          fault_count++;
        end
      end
      rx_wait = draw_wait(sink_calm) + 1;
    end
  end

  // Stimulus
  initial begin
    logic [CountW-1:0]    phase_interval [NumPhases];
    logic [ThreadIdW-1:0] tid;
    logic [AddrW-1:0]     addr;
    int unsigned          roll;

    in_if.valid     = 1'b0;
    in_if.thread_id = '0;
    in_if.address   = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.data     = '0;

    // Shadow reset state
    for (int t = 0; t < NumThreads; t++) begin
      for (int i = 0; i < RingDepth; i++) recent_addr[t][i] = '0;
      ring_slot[t] = 0;
      acc_cnt[t]   = '0;
      hit_cnt[t]   = '0;
      last_addr[t] = '0;
    end
    interval_reg = ralm_pkg::DefReportInterval;

    // Address pool: ten clusters of four neighboring words
    for (int i = 0; i < PoolSize; i++) begin
      if (i % 4 == 0) addr_pool[i] = {$urandom, $urandom};
      else addr_pool[i] = addr_pool[i-1] + 64'd8;
    end

    rst_ni = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: cleared ring hits on zero, field extremes, interval edges
    directed_rows.push_back(chk_row(3'd0, 64'd0, 1'b1, 1'b0, 0, 0));
    directed_rows.push_back(chk_row(3'd7, '1, 1'b0, 1'b0, 0, 0));
    directed_rows.push_back(chk_row(3'd7, '1, 1'b1, 1'b0, 0, 0));
    directed_rows.push_back(chk_row(3'd3, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 0, 0));
    directed_rows.push_back(chk_row(3'd3, 64'h0000_0000_0000_0001, 1'b0, 1'b0, 0, 0));
    directed_rows.push_back(chk_row(3'd0, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 0, 0));
    directed_rows.push_back(cfg_row(32'd1));
    // interval drops below the running count of thread 0
    directed_rows.push_back(acc_row(3'd0, 64'd0));
    directed_rows.push_back(chk_row(3'd0, 64'h5555_5555_5555_5555, 1'b1, 1'b1, 1, 1));
    directed_rows.push_back(chk_row(3'd5, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1, 0, 1));
    // zero interval reports on every access
    directed_rows.push_back(cfg_row(32'd0));
    directed_rows.push_back(chk_row(3'd5, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1, 1, 1));
    directed_rows.push_back(chk_row(3'd2, 64'hDEAD_BEEF_0000_1234, 1'b0, 1'b1, 0, 1));
    directed_rows.push_back(cfg_row(32'hFFFF_FFFF));
    directed_rows.push_back(chk_row(3'd1, 64'd0, 1'b1, 1'b0, 0, 0));
    directed_rows.push_back(chk_row(3'd1, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 0, 0));
    directed_rows.push_back(chk_row(3'd4, 64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, 0, 0));
    directed_rows.push_back(cfg_row(32'd3));
    directed_rows.push_back(acc_row(3'd1, 64'h0123_4567_89AB_CDEF));
    directed_rows.push_back(acc_row(3'd4, 64'd0));
    directed_rows.push_back(acc_row(3'd6, 64'h0000_0000_FFFF_FFFF));
    directed_rows.push_back(acc_row(3'd6, 64'h0000_0000_FFFF_FFFF));
    directed_rows.push_back(acc_row(3'd6, 64'h0000_0000_FFFF_FFFF));

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CONFIG)
        write_interval(directed_rows[k].address[CountW-1:0]);
      else
        send_access(directed_rows[k].thread_id, directed_rows[k].address,
                    directed_rows[k].typed, directed_rows[k].want);
    end

    // Random phases; counts left over from the wide interval hit a lower one
    phase_interval = '{32'd1, 32'd3, 32'd7, 32'hFFFF_FFFF, 32'd20,
                       32'($urandom_range(2, 40)), 32'd2};
    tid = '0;
    for (int p = 0; p < NumPhases; p++) begin
      write_interval(phase_interval[p]);
      if (p == 2) hold_off_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 9) >= 3) tid = ThreadIdW'($urandom_range(0, NumThreads - 1));
        roll = $urandom_range(0, 99);
        if (roll < 55) addr = addr_pool[$urandom_range(0, PoolSize - 1)];
        else if (roll < 70) addr = last_addr[tid];
        else if (roll < 92) addr = {$urandom, $urandom};
        else if (roll < 96) addr = '0;
        else addr = '1;
        last_addr[tid] = addr;
        send_access(tid, addr, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    if (fault_count == 0)
      $display("recent_address_locality_monitor_unit test passed");
    else
      $display("recent_address_locality_monitor_unit test failed");
    $finish;
  end

endmodule
